@@ rtl/core/shared_palette_merge_allocator_top_macros.svh @@
// assertion macros for the shared palette merge allocator
// used by shared_palette_merge_allocator_top, relies on its clock and reset ports
`ifndef SHARED_PALETTE_MERGE_ALLOCATOR_TOP_MACROS_SVH
`define SHARED_PALETTE_MERGE_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define SPMA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spma assertion failed");

// next-cycle implication
`define SPMA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spma assertion failed");

`endif

@@ rtl/core/spma_pkg.sv @@
// shared constants, codes and helpers of the shared palette merge allocator
// no dependencies
package spma_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int NUM_PALETTES    = 4;
   localparam int COUNT_WIDTH     = 16;
   localparam int COLOR_WIDTH     = 16;

   localparam int SLOT_W   = $clog2(PALETTE_ENTRIES);
   localparam int PAL_W    = $clog2(NUM_PALETTES);
   localparam int PTR_W    = SLOT_W + 1;
   localparam int ADDR_W   = PAL_W + SLOT_W;
   localparam int RAM_DEPTH = NUM_PALETTES * PALETTE_ENTRIES;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [0:0] {
      CMD_MERGE   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_REUSED    = 2'd0,
      STAT_NEW       = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_UNDERFLOW = 2'd3
   } status_type;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_RD    = 7'b0000100,
      ST_CHK   = 7'b0001000,
      ST_SCAN  = 7'b0010000,
      ST_WR    = 7'b0100000,
      ST_NCLR  = 7'b1000000
   } state_type;

   // saturating increment of a use count
   function automatic logic [COUNT_WIDTH-1:0] bump_count(input logic [COUNT_WIDTH-1:0] cnt);
      logic [COUNT_WIDTH-1:0] res;
      res = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_WIDTH'(1);
      return res;
   endfunction

endpackage

@@ rtl/core/spma_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module spma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/shared_palette_merge_allocator_top.sv @@
// top level of the shared palette merge allocator: sequencer, scan compare, bookkeeping
// depends on spma_pkg, spma_ram and shared_palette_merge_allocator_top_macros.svh
//
// usage:
//   req channel carries one request: merge one image color or release one slot use.
//   rsp channel returns exactly one result per request: slot and status.
//   a merge with first_color set starts an image; if entry 0 of the palette is unused
//   the image is copied slot for slot, else colors reuse matching live entries or take
//   the next free slot at or above the allocation pointer.
// sequence per request (accept to result, then back to idle for the next request):
//   release and copy-mode colors go through read, check and write; a copy past the last
//   slot goes straight to write. image start: the per-slot new-this-image flags are
//   cleared one per cycle. a shared-palette merge scans one entry per cycle with a single
//   compare unit and stops at the first match, else at the last entry.
// reset:
//   a clearing pass writes zero to all 1024 count and color entries and the 256 flags,
//   during which req_tready stays low.
// stall:
//   a result waits in the output register until taken; the next request may be accepted
//   meanwhile, and its result holds the block busy until the register frees up.
`include "shared_palette_merge_allocator_top_macros.svh"

module shared_palette_merge_allocator_top
   import spma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // color [15:0], release_slot [23:16]
   input  logic [3:0]  req_tuser,   // cmd [0], palette_select [2:1], first_color [3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // slot [7:0]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   state_type                   state_ff, state_in;
   logic [ADDR_W-1:0]           clr_ff, clr_in;
   cmd_type                     cmd_ff, cmd_in;
   logic [PAL_W-1:0]            pal_ff, pal_in;
   logic                        first_ff, first_in;
   logic [COLOR_WIDTH-1:0]      color_ff, color_in;
   logic [SLOT_W-1:0]           rel_ff, rel_in;
   logic                        copy_ff, copy_in;
   logic [PTR_W-1:0]            ap_ff, ap_in;
   logic [PTR_W-1:0]            scan_ff, scan_in;
   logic                        chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0]           chk_idx_ff, chk_idx_in;
   logic                        free_vld_ff, free_vld_in;
   logic [SLOT_W-1:0]           free_idx_ff, free_idx_in;
   logic [SLOT_W-1:0]           wr_idx_ff, wr_idx_in;
   logic [COUNT_WIDTH-1:0]      wr_cnt_ff, wr_cnt_in;
   logic                        wr_cnt_en_ff, wr_cnt_en_in;
   logic                        wr_col_en_ff, wr_col_en_in;
   logic                        wr_nti_en_ff, wr_nti_en_in;
   status_type                  wr_status_ff, wr_status_in;
   logic                        rsp_vld_ff, rsp_vld_in;
   logic [SLOT_W-1:0]           rsp_slot_ff, rsp_slot_in;
   status_type                  rsp_status_ff, rsp_status_in;

   logic                        req_acc;
   logic                        wr_adv;
   logic [SLOT_W-1:0]           rd_idx;
   logic [ADDR_W-1:0]           raddr;
   logic [ADDR_W-1:0]           waddr;
   logic                        cnt_we;
   logic                        col_we;
   logic [COUNT_WIDTH-1:0]      cnt_wdata;
   logic [COLOR_WIDTH-1:0]      col_wdata;
   logic [COUNT_WIDTH-1:0]      cnt_rd;
   logic [COLOR_WIDTH-1:0]      col_rd;
   logic                        nti_we;
   logic [SLOT_W-1:0]           nti_waddr;
   logic                        nti_wdata;
   logic                        nti_rd;
   logic                        hit;
   logic                        free_here;
   logic [SLOT_W-1:0]           alloc_idx;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign wr_adv     = (state_ff == ST_WR) & (~rsp_vld_ff | rsp_tready);

   // single-entry read index for release, image start and copy-mode colors
   always_comb begin
      if (cmd_ff == CMD_RELEASE) begin
         rd_idx = rel_ff;
      end else if (first_ff) begin
         rd_idx = '0;
      end else begin
         rd_idx = ap_ff[SLOT_W-1:0];
      end
   end

   assign raddr = (state_ff == ST_SCAN) ? {pal_ff, scan_ff[SLOT_W-1:0]} : {pal_ff, rd_idx};

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         waddr     = clr_ff;
         cnt_we    = 1'b1;
         col_we    = 1'b1;
         cnt_wdata = '0;
         col_wdata = '0;
      end else begin
         waddr     = {pal_ff, wr_idx_ff};
         cnt_we    = wr_adv & wr_cnt_en_ff;
         col_we    = wr_adv & wr_col_en_ff;
         cnt_wdata = wr_cnt_ff;
         col_wdata = color_ff;
      end
   end

   // new-this-image flags: cleared after reset and at every image start
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         nti_waddr = clr_ff[SLOT_W-1:0];
         nti_we    = 1'b1;
         nti_wdata = 1'b0;
      end else if (state_ff == ST_NCLR) begin
         nti_waddr = scan_ff[SLOT_W-1:0];
         nti_we    = 1'b1;
         nti_wdata = 1'b0;
      end else begin
         nti_waddr = wr_idx_ff;
         nti_we    = wr_adv & wr_nti_en_ff;
         nti_wdata = 1'b1;
      end
   end

   spma_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(RAM_DEPTH)) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (waddr),
      .wdata (cnt_wdata),
      .raddr (raddr),
      .rdata (cnt_rd)
   );

   spma_ram #(.WIDTH(COLOR_WIDTH), .DEPTH(RAM_DEPTH)) u_color_ram (
      .clock (clock),
      .we    (col_we),
      .waddr (waddr),
      .wdata (col_wdata),
      .raddr (raddr),
      .rdata (col_rd)
   );

   spma_ram #(.WIDTH(1), .DEPTH(PALETTE_ENTRIES)) u_nti_ram (
      .clock (clock),
      .we    (nti_we),
      .waddr (nti_waddr),
      .wdata (nti_wdata),
      .raddr (scan_ff[SLOT_W-1:0]),
      .rdata (nti_rd)
   );

   // scan compare unit
   assign hit       = (cnt_rd != '0) & ~nti_rd & (col_rd == color_ff);
   assign free_here = (cnt_rd == '0) & ({1'b0, chk_idx_ff} >= ap_ff);
   assign alloc_idx = free_vld_ff ? free_idx_ff : chk_idx_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      pal_in        = pal_ff;
      first_in      = first_ff;
      color_in      = color_ff;
      rel_in        = rel_ff;
      copy_in       = copy_ff;
      ap_in         = ap_ff;
      scan_in       = scan_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      wr_idx_in     = wr_idx_ff;
      wr_cnt_in     = wr_cnt_ff;
      wr_cnt_en_in  = wr_cnt_en_ff;
      wr_col_en_in  = wr_col_en_ff;
      wr_nti_en_in  = wr_nti_en_ff;
      wr_status_in  = wr_status_ff;
      rsp_vld_in    = rsp_vld_ff & ~rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               cmd_in   = cmd_type'(req_tuser[0]);
               pal_in   = req_tuser[PAL_W:1];
               first_in = req_tuser[3];
               color_in = req_tdata[COLOR_WIDTH-1:0];
               rel_in   = req_tdata[16 +: SLOT_W];
               if (req_tuser[0] == CMD_MERGE && !req_tuser[3] && copy_ff) begin
                  if (ap_ff[SLOT_W]) begin
                     // copy ran past the last slot
                     wr_idx_in    = '0;
                     wr_cnt_en_in = 1'b0;
                     wr_col_en_in = 1'b0;
                     wr_nti_en_in = 1'b0;
                     wr_status_in = STAT_FULL;
                     state_in     = ST_WR;
                  end else begin
                     state_in = ST_RD;
                  end
               end else if (req_tuser[0] == CMD_MERGE && !req_tuser[3]) begin
                  scan_in     = '0;
                  free_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            state_in     = ST_WR;
            wr_col_en_in = 1'b0;
            wr_nti_en_in = 1'b0;
            wr_cnt_en_in = 1'b1;
            wr_cnt_in    = bump_count(cnt_rd);
            wr_status_in = STAT_REUSED;
            if (cmd_ff == CMD_RELEASE) begin
               wr_idx_in = rel_ff;
               wr_cnt_in = cnt_rd - COUNT_WIDTH'(1);
               if (cnt_rd == '0) begin
                  wr_cnt_en_in = 1'b0;
                  wr_status_in = STAT_UNDERFLOW;
               end
            end else if (first_ff) begin
               wr_idx_in    = '0;
               copy_in      = (cnt_rd == '0);
               wr_col_en_in = (cnt_rd == '0);
               ap_in        = (cnt_rd == '0) ? PTR_W'(1) : '0;
               scan_in      = '0;
               state_in     = ST_NCLR;
            end else begin
               wr_idx_in    = ap_ff[SLOT_W-1:0];
               wr_col_en_in = 1'b1;
               ap_in        = ap_ff + PTR_W'(1);
            end
         end
         ST_NCLR: begin
            scan_in = scan_ff + PTR_W'(1);
            if (&scan_ff[SLOT_W-1:0]) begin
               state_in = ST_WR;
            end
         end
         ST_SCAN: begin
            if (!scan_ff[SLOT_W]) begin
               scan_in    = scan_ff + PTR_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[SLOT_W-1:0];
            end
            if (chk_vld_ff) begin
               if (hit) begin
                  wr_idx_in    = chk_idx_ff;
                  wr_cnt_in    = bump_count(cnt_rd);
                  wr_cnt_en_in = 1'b1;
                  wr_col_en_in = 1'b0;
                  wr_nti_en_in = 1'b0;
                  wr_status_in = STAT_REUSED;
                  chk_vld_in   = 1'b0;
                  state_in     = ST_WR;
               end else begin
                  if (free_here && !free_vld_ff) begin
                     free_vld_in = 1'b1;
                     free_idx_in = chk_idx_ff;
                  end
                  if (&chk_idx_ff) begin
                     state_in   = ST_WR;
                     chk_vld_in = 1'b0;
                     if (free_vld_ff || free_here) begin
                        wr_idx_in    = alloc_idx;
                        wr_cnt_in    = COUNT_WIDTH'(1);
                        wr_cnt_en_in = 1'b1;
                        wr_col_en_in = 1'b1;
                        wr_nti_en_in = 1'b1;
                        wr_status_in = STAT_NEW;
                        ap_in        = {1'b0, alloc_idx} + PTR_W'(1);
                     end else begin
                        wr_idx_in    = '0;
                        wr_cnt_en_in = 1'b0;
                        wr_col_en_in = 1'b0;
                        wr_nti_en_in = 1'b0;
                        wr_status_in = STAT_FULL;
                     end
                  end
               end
            end
         end
         ST_WR: begin
            if (wr_adv) begin
               rsp_vld_in    = 1'b1;
               rsp_slot_in   = wr_idx_ff;
               rsp_status_in = wr_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         copy_ff    <= 1'b0;
         ap_ff      <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         copy_ff    <= copy_in;
         ap_ff      <= ap_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pal_ff        <= pal_in;
      first_ff      <= first_in;
      color_ff      <= color_in;
      rel_ff        <= rel_in;
      scan_ff       <= scan_in;
      chk_idx_ff    <= chk_idx_in;
      free_vld_ff   <= free_vld_in;
      free_idx_ff   <= free_idx_in;
      wr_idx_ff     <= wr_idx_in;
      wr_cnt_ff     <= wr_cnt_in;
      wr_cnt_en_ff  <= wr_cnt_en_in;
      wr_col_en_ff  <= wr_col_en_in;
      wr_nti_en_ff  <= wr_nti_en_in;
      wr_status_ff  <= wr_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_slot_ff;
   assign rsp_tuser  = rsp_status_ff;

   `SPMA_ASSERT_NOW(a_ptr_range, 1'b1, ap_ff <= PTR_W'(PALETTE_ENTRIES))
   `SPMA_ASSERT_NOW(a_scan_order, (state_ff == ST_SCAN) && chk_vld_ff,
                    ({1'b0, chk_idx_ff} + PTR_W'(1)) == scan_ff)
   `SPMA_ASSERT_NOW(a_scan_shared, state_ff == ST_SCAN, !copy_ff)
   `SPMA_ASSERT_NEXT(a_result_load, (state_ff == ST_WR) && !rsp_vld_ff,
                     rsp_vld_ff && (state_ff == ST_IDLE))
   `SPMA_ASSERT_NOW(a_no_write_idle, state_ff == ST_IDLE, !cnt_we && !col_we)

endmodule

@@ test/shared_palette_merge_allocator_top_tb.sv @@
// self-checking testbench for shared_palette_merge_allocator_top: merges, releases, copy mode,
// palette full, a long result stall; a scoreboard class predicts slot and status per request
// depends on spma_pkg and the rtl of shared_palette_merge_allocator_top
module shared_palette_merge_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spma_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 600;

   typedef struct {
      cmd_type                cmd;
      logic [PAL_W-1:0]       palette;
      logic                   first_color;
      logic [COLOR_WIDTH-1:0] color;
      logic [SLOT_W-1:0]      release_slot;
   } palette_req;

   typedef struct {
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } slot_grant;

   class palette_scoreboard;
      logic [COLOR_WIDTH-1:0] color_mem [NUM_PALETTES][PALETTE_ENTRIES];
      logic [COUNT_WIDTH-1:0] use_mem [NUM_PALETTES][PALETTE_ENTRIES];
      bit                     added_now [PALETTE_ENTRIES];
      bit                     copying;
      int unsigned            alloc_ptr;
      slot_grant              grants_due [$];
      int                     mismatches;
      int                     status_seen [4];

      function new();
         foreach (color_mem[p, i]) begin
            color_mem[p][i] = '0;
            use_mem[p][i] = '0;
         end
         foreach (added_now[i]) added_now[i] = 1'b0;
         foreach (status_seen[i]) status_seen[i] = 0;
         copying = 1'b0;
         alloc_ptr = 0;
         mismatches = 0;
      endfunction

      function void bump(int p, int i);
         if (use_mem[p][i] != COUNT_MAX) use_mem[p][i]++;
      endfunction

      function slot_grant predict_grant(palette_req r);
         slot_grant g;
         int p;
         int i;
         p = int'(r.palette) % NUM_PALETTES;
         g.slot = '0;
         g.status = STAT_REUSED;
         if (r.cmd == CMD_RELEASE) begin
            g.slot = r.release_slot;
            if (use_mem[p][r.release_slot] == 0) g.status = STAT_UNDERFLOW;
            else use_mem[p][r.release_slot]--;
            return g;
         end
         if (r.first_color) begin
            // an unused entry 0 means the image is copied slot for slot
            copying = (use_mem[p][0] == 0);
            foreach (added_now[j]) added_now[j] = 1'b0;
            if (copying) begin
               color_mem[p][0] = r.color;
               alloc_ptr = 1;
            end else begin
               alloc_ptr = 0;
            end
            bump(p, 0);
            return g;
         end
         if (copying) begin
            if (alloc_ptr >= PALETTE_ENTRIES) begin
               g.status = STAT_FULL;
               return g;
            end
            color_mem[p][alloc_ptr] = r.color;
            bump(p, alloc_ptr);
            g.slot = SLOT_W'(alloc_ptr);
            alloc_ptr++;
            return g;
         end
         // entries added by this image are not candidates for reuse
         for (i = 0; i < PALETTE_ENTRIES; i++) begin
            if (use_mem[p][i] != 0 && !added_now[i] && color_mem[p][i] == r.color) begin
               bump(p, i);
               g.slot = SLOT_W'(i);
               return g;
            end
         end
         for (i = int'(alloc_ptr); i < PALETTE_ENTRIES; i++) begin
            if (use_mem[p][i] == 0) begin
               color_mem[p][i] = r.color;
               bump(p, i);
               added_now[i] = 1'b1;
               alloc_ptr = i + 1;
               g.slot = SLOT_W'(i);
               g.status = STAT_NEW;
               return g;
            end
         end
         g.status = STAT_FULL;
         return g;
      endfunction

      function void note_request(palette_req r);
         grants_due.push_back(predict_grant(r));
      endfunction

      function void check_result(logic [SLOT_W-1:0] slot, logic [1:0] status);
         slot_grant due;
         if (grants_due.size() == 0) begin
            $error("result with no request outstanding: slot %0d status %0d", slot, status);
            mismatches++;
            return;
         end
         due = grants_due.pop_front();
         status_seen[due.status]++;
         if (slot !== due.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", due.slot, slot);
            mismatches++;
         end
         if (status !== due.status) begin
            $error("status mismatch: expected %0d, actual %0d", due.status, status);
            mismatches++;
         end
      endfunction

      function int live_slot(int p);
         int start;
         int k;
         start = $urandom_range(PALETTE_ENTRIES - 1);
         for (k = 0; k < PALETTE_ENTRIES; k++) begin
            if (use_mem[p][(start + k) % PALETTE_ENTRIES] != 0)
               return (start + k) % PALETTE_ENTRIES;
         end
         return -1;
      endfunction

      function int use_count(int p, int s);
         return int'(use_mem[p][s]);
      endfunction

      function int outstanding();
         return grants_due.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // color [15:0], release_slot [23:16]
   logic [3:0]  req_tuser = '0;   // cmd [0], palette_select [2:1], first_color [3]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // slot [7:0]
   logic [1:0]  rsp_tuser;        // status [1:0]

   palette_scoreboard sb = new();
   int send_idle_pct = 16;
   int recv_idle_pct = 60;
   int reqs_sent = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit start_hold = 1'b0;
   logic [COLOR_WIDTH-1:0] color_pool [16];

   shared_palette_merge_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // result side: check, then decide readiness for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (start_hold) begin
            hold_left = HOLD_CYCLES;
            start_hold = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("shared_palette_merge_allocator_top test failed");
         $finish;
      end
   end

   function automatic palette_req merge_req(int p, bit first, logic [COLOR_WIDTH-1:0] c);
      palette_req r;
      r.cmd = CMD_MERGE;
      r.palette = PAL_W'(p);
      r.first_color = first;
      r.color = c;
      r.release_slot = SLOT_W'($urandom);
      return r;
   endfunction

   function automatic palette_req release_req(int p, int s);
      palette_req r;
      r.cmd = CMD_RELEASE;
      r.palette = PAL_W'(p);
      r.first_color = 1'b0;
      r.color = COLOR_WIDTH'($urandom);
      r.release_slot = SLOT_W'(s);
      return r;
   endfunction

   task automatic send_item(input palette_req r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.release_slot, r.color};
      req_tuser <= {r.first_color, r.palette, r.cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
      reqs_sent++;
   endtask

   // color_mode: 0 colors from the shared pool, 1 random colors, 2 a run of distinct colors
   task automatic send_image(input int p, input int n_colors, input int color_mode);
      logic [COLOR_WIDTH-1:0] base;
      logic [COLOR_WIDTH-1:0] c;
      int pal;
      int k;
      base = COLOR_WIDTH'($urandom);
      send_item(merge_req(p, 1'b1, (color_mode == 0) ? color_pool[$urandom_range(15)] : base));
      for (k = 1; k <= n_colors; k++) begin
         case (color_mode)
            0: c = color_pool[$urandom_range(15)];
            1: c = COLOR_WIDTH'($urandom);
            default: c = base + COLOR_WIDTH'(k);
         endcase
         // now and then a color names another palette in the middle of an image
         pal = ($urandom_range(99) < 5) ? $urandom_range(NUM_PALETTES - 1) : p;
         send_item(merge_req(pal, 1'b0, c));
      end
   endtask

   task automatic run_random(input int n_reqs);
      palette_req r;
      int first_req;
      int pick;
      int p;
      int s;
      int c;
      first_req = reqs_sent;
      while (reqs_sent - first_req < n_reqs) begin
         pick = $urandom_range(199);
         p = $urandom_range(NUM_PALETTES - 1);
         if (pick < 100) begin
            send_image(p, $urandom_range(1, 12), ($urandom_range(9) < 6) ? 0 : 1);
         end else if (pick < 145) begin
            repeat ($urandom_range(1, 6)) begin
               s = sb.live_slot(p);
               if (s < 0 || $urandom_range(3) == 0) s = $urandom_range(PALETTE_ENTRIES - 1);
               send_item(release_req(p, s));
            end
         end else if (pick < 155) begin
            // free entry 0 completely so the next image on this palette copies
            c = sb.use_count(p, 0);
            if (c <= 64) repeat (c + 1) send_item(release_req(p, 0));
         end else if (pick < 156) begin
            send_image(p, $urandom_range(240, 270), 2);
         end else begin
            r.cmd = cmd_type'($urandom_range(1));
            r.palette = PAL_W'($urandom);
            r.first_color = 1'($urandom);
            r.color = COLOR_WIDTH'($urandom);
            r.release_slot = SLOT_W'($urandom);
            send_item(r);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      palette_req r;
      foreach (color_pool[i]) color_pool[i] = COLOR_WIDTH'($urandom);
      color_pool[0] = 16'h0000;
      color_pool[1] = 16'hFFFF;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: merge before any image, underflows, copy image, shared image
      send_item(merge_req(0, 1'b0, 16'h1234));
      send_item(release_req(1, 0));
      send_item(release_req(0, 255));
      send_item(merge_req(1, 1'b1, 16'hFFFF));
      send_item(merge_req(1, 1'b0, 16'h0000));
      send_item(merge_req(1, 1'b0, 16'hFFFF));
      send_item(merge_req(1, 1'b0, 16'h8001));
      send_item(merge_req(1, 1'b1, 16'h0001));
      send_item(merge_req(1, 1'b0, 16'h0000));
      send_item(merge_req(1, 1'b0, 16'hABCD));
      send_item(merge_req(1, 1'b0, 16'hABCD));
      send_item(merge_req(2, 1'b0, 16'h5A5A));
      send_item(merge_req(1, 1'b0, 16'h1234));
      send_item(release_req(1, 4));
      send_item(release_req(1, 4));
      r = release_req(1, 5);
      r.first_color = 1'b1;
      r.color = 16'hFFFF;
      send_item(r);
      send_item(release_req(0, 0));
      send_item(merge_req(0, 1'b1, 16'h00FF));
      send_item(merge_req(0, 1'b0, 16'hFF00));
      wait_drained();

      // copy that runs past the last slot, then a shared image on the full palette
      send_image(3, 260, 2);
      send_image(3, 20, 2);

      start_hold = 1'b1;
      run_random(500);
      wait_drained();

      send_idle_pct = 60;
      recv_idle_pct = 16;
      run_random(500);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(450);
      wait_drained();
      repeat (300) @(posedge clock);

      $display("covered %0d requests: %0d reused or copied, %0d new, %0d full, %0d underflow",
               reqs_sent, sb.status_seen[STAT_REUSED], sb.status_seen[STAT_NEW],
               sb.status_seen[STAT_FULL], sb.status_seen[STAT_UNDERFLOW]);
      $display("copy overrun, full palette, mid-image palette switches and a long result stall");
      if (sb.mismatches == 0) begin
         $display("shared_palette_merge_allocator_top test passed");
      end else begin
         $display("shared_palette_merge_allocator_top test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/spma_pkg.sv
rtl/core/spma_ram.sv
rtl/core/shared_palette_merge_allocator_top.sv
test/shared_palette_merge_allocator_top_tb.sv
